// ----- design/brl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brl_pkg
// shared types and constants of the line rasterizer core: field widths,
// register indexes, reset values, sequencer states and the segment setup word
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int MAX_SPAN_DEFAULT   = 63;
    localparam int COORD_BITS_DEFAULT = 12;

    localparam int FIELD_COORD_BITS = 12;
    localparam int DELTA_BITS       = 7;
    localparam int MAG_BITS         = 7;
    localparam int DEC_BITS         = 9;
    localparam int DIM_BITS         = 11;
    localparam int STRIDE_BITS      = 13;
    localparam int ADDR_BITS        = 24;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 13;

    localparam logic [DIM_BITS-1:0]    WIDTH_RESET  = 11'd1920;
    localparam logic [DIM_BITS-1:0]    HEIGHT_RESET = 11'd1080;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 13'd1920;

    localparam logic signed [DEC_BITS-1:0] DEC_MAX = 9'sd255;
    localparam logic signed [DEC_BITS-1:0] DEC_MIN = -9'sd256;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WINDOW_WIDTH  = 2'd0,
        CFG_WINDOW_HEIGHT = 2'd1,
        CFG_ROW_STRIDE    = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef struct packed {
        logic                          y_major;
        logic signed [DELTA_BITS-1:0]  delta_x;
        logic signed [DELTA_BITS-1:0]  delta_y;
    } seg_setup_t;

endpackage

`default_nettype wire

// ----- design/bresenham_line_rasterizer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core
// steps one line segment with an integer decision value and emits one pixel
// word per step, with window test and frame-buffer word address
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  segment  | in_valid/in_ready, start_x/y, delta_x/y,  | in
//           | y_major                                   |
//  pixel    | out_valid/out_ready, pixel_x/y, visible,  | out
//           | word_address, last_pixel                  |
//  config   | cfg_we, cfg_index, cfg_wdata              | in
//
//  a segment gives min(|major delta|, MAX_SPAN) + 1 pixel words from the shared step
//  unit (decision adder and coordinate incrementers), one per cycle while out_ready is high
//  a segment occupies the core until its last pixel word is taken
//  in_ready is high only while no segment is in flight
//  a low out_ready holds the step unit and the current word
//  rst_n clears the sequencer and restores the register defaults
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_core #(
    parameter int MAX_SPAN   = brl_pkg::MAX_SPAN_DEFAULT,
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,

    input  wire logic                                       cfg_we,
    input  wire logic [brl_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  wire logic [brl_pkg::CFG_DATA_BITS-1:0]          cfg_wdata,

    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire logic signed [brl_pkg::FIELD_COORD_BITS-1:0] start_x,
    input  wire logic signed [brl_pkg::FIELD_COORD_BITS-1:0] start_y,
    input  wire logic signed [brl_pkg::DELTA_BITS-1:0]      delta_x,
    input  wire logic signed [brl_pkg::DELTA_BITS-1:0]      delta_y,
    input  wire logic                                       y_major,

    output logic                                            out_valid,
    input  wire logic                                       out_ready,
    output logic signed [brl_pkg::FIELD_COORD_BITS-1:0]     pixel_x,
    output logic signed [brl_pkg::FIELD_COORD_BITS-1:0]     pixel_y,
    output logic                                            visible,
    output logic [brl_pkg::ADDR_BITS-1:0]                   word_address,
    output logic                                            last_pixel
);
    import brl_pkg::*;

    localparam int SPAN_BITS = $clog2(MAX_SPAN + 1);
    localparam int EXT_BITS  = (COORD_BITS > FIELD_COORD_BITS) ? COORD_BITS
                                                               : FIELD_COORD_BITS;

    // configuration registers
    logic [DIM_BITS-1:0]    window_width_reg;
    logic [DIM_BITS-1:0]    window_height_reg;
    logic [STRIDE_BITS-1:0] row_stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_width_reg  <= WIDTH_RESET;
            window_height_reg <= HEIGHT_RESET;
            row_stride_reg    <= STRIDE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_wdata[DIM_BITS-1:0];
                CFG_WINDOW_HEIGHT: window_height_reg <= cfg_wdata[DIM_BITS-1:0];
                CFG_ROW_STRIDE:    row_stride_reg    <= cfg_wdata[STRIDE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // sequencer and step state
    state_t                        state_reg, state_next;
    logic signed [COORD_BITS-1:0]  cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0]  cur_y_reg, cur_y_next;
    logic signed [DEC_BITS-1:0]    decision_reg, decision_next;
    logic [SPAN_BITS-1:0]          steps_left_reg, steps_left_next;
    seg_setup_t                    seg_reg, seg_next;

    // output word
    logic signed [FIELD_COORD_BITS-1:0] pixel_x_reg, pixel_x_next;
    logic signed [FIELD_COORD_BITS-1:0] pixel_y_reg, pixel_y_next;
    logic                               visible_reg, visible_next;
    logic [ADDR_BITS-1:0]               word_address_reg, word_address_next;
    logic                               last_pixel_reg, last_pixel_next;

    // shared step unit
    seg_setup_t                    act_seg;
    logic signed [DELTA_BITS-1:0]  major_d, minor_d;
    logic [MAG_BITS-1:0]           big_mag, small_mag;
    logic                          maj_pos, min_pos;
    logic signed [DEC_BITS:0]      two_m, two_big, dec_inc;
    logic signed [DEC_BITS+1:0]    dec_sum;
    logic signed [DEC_BITS-1:0]    dec_stepped, dec_init;
    logic signed [COORD_BITS-1:0]  maj_inc, min_inc, x_inc, y_inc;
    logic signed [COORD_BITS-1:0]  stepped_x, stepped_y;
    logic [SPAN_BITS-1:0]          span_steps;
    logic signed [COORD_BITS-1:0]  start_cx, start_cy;

    // pixel test
    logic signed [COORD_BITS-1:0]  emit_x, emit_y;
    logic signed [EXT_BITS-1:0]    emit_x_ext, emit_y_ext;
    logic signed [EXT_BITS-1:0]    width_ext, height_ext;
    logic                          emit_visible;
    logic [ADDR_BITS-1:0]          emit_address;

    logic load_start;
    logic advance;

    assign act_seg = (state_reg == ST_IDLE) ? seg_setup_t'{y_major: y_major,
                                                            delta_x: delta_x,
                                                            delta_y: delta_y}
                                            : seg_reg;

    always_comb
    begin
        major_d   = act_seg.y_major ? act_seg.delta_y : act_seg.delta_x;
        minor_d   = act_seg.y_major ? act_seg.delta_x : act_seg.delta_y;
        big_mag   = major_d[DELTA_BITS-1] ? MAG_BITS'(-major_d) : MAG_BITS'(major_d);
        small_mag = minor_d[DELTA_BITS-1] ? MAG_BITS'(-minor_d) : MAG_BITS'(minor_d);
        maj_pos   = !major_d[DELTA_BITS-1] && (major_d != '0);
        min_pos   = !minor_d[DELTA_BITS-1] && (minor_d != '0);

        two_m    = $signed({2'b00, small_mag, 1'b0});
        two_big  = $signed({2'b00, big_mag, 1'b0});
        dec_init = DEC_BITS'(two_m - $signed({3'b000, big_mag}));

        // negative decision: gain 2m, else move minor and gain 2m - 2M
        dec_inc  = decision_reg[DEC_BITS-1] ? two_m : (two_m - two_big);
        dec_sum  = (DEC_BITS+2)'(decision_reg) + (DEC_BITS+2)'(dec_inc);
        if (dec_sum > (DEC_BITS+2)'(DEC_MAX))
            dec_stepped = DEC_MAX;
        else if (dec_sum < (DEC_BITS+2)'(DEC_MIN))
            dec_stepped = DEC_MIN;
        else
            dec_stepped = DEC_BITS'(dec_sum);

        maj_inc = maj_pos ? COORD_BITS'(1) : COORD_BITS'(-1);
        min_inc = decision_reg[DEC_BITS-1] ? '0
                                           : (min_pos ? COORD_BITS'(1) : COORD_BITS'(-1));
        x_inc   = act_seg.y_major ? min_inc : maj_inc;
        y_inc   = act_seg.y_major ? maj_inc : min_inc;
        stepped_x = cur_x_reg + x_inc;
        stepped_y = cur_y_reg + y_inc;

        span_steps = (big_mag > MAG_BITS'(MAX_SPAN)) ? SPAN_BITS'(MAX_SPAN)
                                                     : SPAN_BITS'(big_mag);

        start_cx = COORD_BITS'(EXT_BITS'(start_x));
        start_cy = COORD_BITS'(EXT_BITS'(start_y));
    end

    assign load_start = (state_reg == ST_IDLE) && in_valid;
    assign advance    = (state_reg == ST_RUN) && out_ready && (steps_left_reg != '0);

    // window test and address of the pixel about to be loaded
    always_comb
    begin
        emit_x     = (state_reg == ST_IDLE) ? start_cx : stepped_x;
        emit_y     = (state_reg == ST_IDLE) ? start_cy : stepped_y;
        emit_x_ext = EXT_BITS'(emit_x);
        emit_y_ext = EXT_BITS'(emit_y);
        width_ext  = $signed({{(EXT_BITS-DIM_BITS){1'b0}}, window_width_reg});
        height_ext = $signed({{(EXT_BITS-DIM_BITS){1'b0}}, window_height_reg});

        emit_visible = (emit_x_ext > $signed(EXT_BITS'(0))) && (emit_x_ext < width_ext)
                    && (emit_y_ext > $signed(EXT_BITS'(0))) && (emit_y_ext < height_ext);

        emit_address = '0;
        if (emit_visible)
            emit_address = ADDR_BITS'(ADDR_BITS'(emit_y_ext[DIM_BITS-1:0])
                                      * ADDR_BITS'(row_stride_reg))
                         + ADDR_BITS'(emit_x_ext[DIM_BITS-1:0]);
    end

    // next state and outputs
    always_comb
    begin
        state_next        = state_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        decision_next     = decision_reg;
        steps_left_next   = steps_left_reg;
        seg_next          = seg_reg;
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        visible_next      = visible_reg;
        word_address_next = word_address_reg;
        last_pixel_next   = last_pixel_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (load_start)
                begin
                    state_next      = ST_RUN;
                    seg_next        = act_seg;
                    cur_x_next      = start_cx;
                    cur_y_next      = start_cy;
                    decision_next   = dec_init;
                    steps_left_next = span_steps;
                    last_pixel_next = (span_steps == '0);
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    cur_x_next      = stepped_x;
                    cur_y_next      = stepped_y;
                    decision_next   = dec_stepped;
                    steps_left_next = steps_left_reg - SPAN_BITS'(1);
                    last_pixel_next = (steps_left_reg == SPAN_BITS'(1));
                end
                else if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_start || advance)
        begin
            pixel_x_next      = FIELD_COORD_BITS'(EXT_BITS'(emit_x));
            pixel_y_next      = FIELD_COORD_BITS'(EXT_BITS'(emit_y));
            visible_next      = emit_visible;
            word_address_next = emit_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            decision_reg   <= '0;
            steps_left_reg <= '0;
            seg_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            decision_reg   <= decision_next;
            steps_left_reg <= steps_left_next;
            seg_reg        <= seg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg      <= pixel_x_next;
        pixel_y_reg      <= pixel_y_next;
        visible_reg      <= visible_next;
        word_address_reg <= word_address_next;
        last_pixel_reg   <= last_pixel_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_RUN);
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign visible      = visible_reg;
    assign word_address = word_address_reg;
    assign last_pixel   = last_pixel_reg;

    // checks
    a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_pixel == (steps_left_reg == '0)))
        else $error("last_pixel out of step with the remaining step count");

    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_left_reg <= SPAN_BITS'(MAX_SPAN))
        else $error("step count above the span limit");

    a_start_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (out_valid && !in_ready))
        else $error("accepted segment did not raise a word");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_pixel) |=> (in_ready && !out_valid))
        else $error("segment did not end after its last word");

    a_address_zero_off_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (word_address == '0))
        else $error("address set on a pixel outside the window");

endmodule

`default_nettype wire
